/* hdl/imm_pkg.sv */
// shared constants for the integer matrix multiply unit
package imm_pkg;

	// default sizing
	localparam int MAX_DIM_DEF    = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 6;
	localparam int ELEM_W  = 32;
	localparam int SIZE_REG_W = 7;
	localparam int CFG_IDX_W  = 2;

	// item modes
	localparam logic [MODE_W-1:0] MODE_WRITE_LEFT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE_RIGHT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

	// size register reset value
	localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd64;

endpackage

/* hdl/imm_ram.sv */
// generic simple dual-port ram with registered read
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/integer_matrix_multiply_unit.sv */
// top level of the integer matrix multiply unit
//
// Usage: an item is taken when start is high and busy is low.
// mode write-left / write-right stores element_value at (row_index, col_index)
// of the left or right matrix in the same cycle; such items give no result
// and the unit stays ready. A write outside the configured size is dropped.
// mode compute asks for result element (row_index, col_index). Outside the
// configured size, result_valid pulses on the next cycle with out_of_range
// set and product_value zero. Otherwise busy rises and one shared multiplier
// and accumulator walk the inner dimension, clamped to MAX_DIM, one
// multiply-accumulate per cycle fed by one read of each matrix ram. Each
// read passes the ram read register and the product register before it is
// added; when the last product is in, the result strobe comes, busy drops
// with it and the next command can be taken. The result word is shown for
// exactly one cycle on result_valid; the receiver cannot stall, so nothing
// waits on it. Sizes are set through cfg_write/cfg_index/cfg_data; the
// user must do so only while idle, as the block does not enforce it.
// Reset sets all three sizes to 64 and returns to idle; the matrix rams are
// not cleared, and entries read before they are written are undefined.
module integer_matrix_multiply_unit
	import imm_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_write,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [SIZE_REG_W-1:0]        cfg_data,
	// command
	input  logic                         start,
	output logic                         busy,
	input  logic [MODE_W-1:0]            mode,
	input  logic [INDEX_W-1:0]           row_index,
	input  logic [INDEX_W-1:0]           col_index,
	input  logic signed [ELEM_W-1:0]     element_value,
	// result
	output logic                         result_valid,
	output logic signed [ELEM_W-1:0]     product_value,
	output logic                         out_of_range
);

	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int SIZE_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = (SIZE_W > SIZE_REG_W) ? SIZE_W : SIZE_REG_W;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                  state_q;
	logic [SIZE_REG_W-1:0]   row_count_q;
	logic [SIZE_REG_W-1:0]   inner_count_q;
	logic [SIZE_REG_W-1:0]   col_count_q;
	logic [CMP_W-1:0]        rows_eff;
	logic [CMP_W-1:0]        inner_eff;
	logic [CMP_W-1:0]        cols_eff;
	logic [CMP_W-1:0]        row_ext;
	logic [CMP_W-1:0]        col_ext;
	logic                    accept;
	logic                    left_wr;
	logic                    right_wr;
	logic                    row_ok;
	logic                    col_ok;
	logic signed [63:0]      elem_ext;
	logic [ADDR_W-1:0]       wr_addr;
	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        col_q;
	logic [SIZE_W-1:0]       inner_q;
	logic [SIZE_W-1:0]       z_q;
	logic                    issue;
	logic                    rd_v_s1;
	logic                    mul_v_s2;
	logic [ELEM_W-1:0]       mul_s2;
	logic [ELEM_W-1:0]       acc_q;
	logic                    done;
	logic [DATA_WIDTH-1:0]   left_rd;
	logic [DATA_WIDTH-1:0]   right_rd;
	logic signed [63:0]      left_ext;
	logic signed [63:0]      right_ext;
	logic [63:0]             full_prod;

	// effective sizes, clamped to the array dimension
	always_comb begin
		rows_eff  = (CMP_W'(row_count_q) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(row_count_q);
		inner_eff = (CMP_W'(inner_count_q) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(inner_count_q);
		cols_eff  = (CMP_W'(col_count_q) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(col_count_q);
	end

	// command decode
	assign accept   = start && !busy;
	assign row_ext  = CMP_W'(row_index);
	assign col_ext  = CMP_W'(col_index);
	assign left_wr  = accept && (mode == MODE_WRITE_LEFT)
		&& (row_ext < rows_eff) && (col_ext < inner_eff);
	assign right_wr = accept && (mode == MODE_WRITE_RIGHT)
		&& (row_ext < inner_eff) && (col_ext < cols_eff);
	assign row_ok   = row_ext < rows_eff;
	assign col_ok   = col_ext < cols_eff;
	assign elem_ext = 64'(element_value);
	assign wr_addr  = {IDX_W'(row_index), IDX_W'(col_index)};

	// read sequencing over the inner dimension
	assign issue = (state_q == ST_RUN) && (z_q != inner_q);
	assign done  = (state_q == ST_RUN) && !issue && !rd_v_s1 && !mul_v_s2;
	assign busy  = (state_q != ST_IDLE);

	imm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_left_ram (
		.clk     (clk),
		.wr_en   (left_wr),
		.wr_addr (wr_addr),
		.wr_data (elem_ext[DATA_WIDTH-1:0]),
		.rd_en   (issue),
		.rd_addr ({row_q, z_q[IDX_W-1:0]}),
		.rd_data (left_rd)
	);

	imm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_right_ram (
		.clk     (clk),
		.wr_en   (right_wr),
		.wr_addr (wr_addr),
		.wr_data (elem_ext[DATA_WIDTH-1:0]),
		.rd_en   (issue),
		.rd_addr ({z_q[IDX_W-1:0], col_q}),
		.rd_data (right_rd)
	);

	// sign-extend stored elements and form the wrapped product
	assign left_ext  = 64'($signed(left_rd));
	assign right_ext = 64'($signed(right_rd));
	assign full_prod = left_ext[31:0] * right_ext[31:0];

	// product register, payload only
	always_ff @(posedge clk) begin
		mul_s2 <= full_prod[ELEM_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= SIZE_RESET;
			inner_count_q <= SIZE_RESET;
			col_count_q   <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ROW_COUNT:   row_count_q   <= cfg_data;
				REG_INNER_COUNT: inner_count_q <= cfg_data;
				REG_COL_COUNT:   col_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, accumulator and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_v_s1       <= 1'b0;
			mul_v_s2      <= 1'b0;
			result_valid  <= 1'b0;
			out_of_range  <= 1'b0;
			product_value <= '0;
			row_q         <= '0;
			col_q         <= '0;
			inner_q       <= '0;
			z_q           <= '0;
			acc_q         <= '0;
		end else begin
			result_valid <= 1'b0;
			rd_v_s1      <= issue;
			mul_v_s2     <= rd_v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_COMPUTE)) begin
						if (!row_ok || !col_ok) begin
							result_valid  <= 1'b1;
							out_of_range  <= 1'b1;
							product_value <= '0;
						end else begin
							state_q <= ST_RUN;
							row_q   <= row_ext[IDX_W-1:0];
							col_q   <= col_ext[IDX_W-1:0];
							inner_q <= inner_eff[SIZE_W-1:0];
							z_q     <= '0;
							acc_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					if (issue) begin
						z_q <= z_q + SIZE_W'(1);
					end
					if (mul_v_s2) begin
						acc_q <= acc_q + mul_s2;
					end
					if (done) begin
						state_q       <= ST_IDLE;
						result_valid  <= 1'b1;
						out_of_range  <= 1'b0;
						product_value <= acc_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the result word is only driven once the unit is idle again
	ap_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result word while busy");

	// an out-of-range result carries a zero product
	ap_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_of_range) |-> (product_value == '0))
		else $error("out-of-range result with nonzero product");

	// the read counter never runs past the latched inner length
	ap_z_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (z_q <= inner_q))
		else $error("inner counter overrun");

	// a compute run only begins from an accepted command
	ap_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without command");

	// no multiply-accumulate is pending while idle
	ap_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_v_s2 |-> busy)
		else $error("product pending while idle");

endmodule

/* tb/sv/integer_matrix_multiply_unit_checker.sv */
// checker for the integer matrix multiply unit: predicts every result word and compares it
module integer_matrix_multiply_unit_checker
	import imm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SIZE_REG_W-1:0]    cfg_data,
	input  logic                     start,
	input  logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [INDEX_W-1:0]       row_index,
	input  logic [INDEX_W-1:0]       col_index,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     result_valid,
	input  logic signed [ELEM_W-1:0] product_value,
	input  logic                     out_of_range,
	output int                       mismatch_count,
	output int                       pending_count
);
	localparam int DIM = MAX_DIM_DEF;

	typedef struct packed {
		logic signed [ELEM_W-1:0] product;
		logic                     out_of_range;
	} result_word_t;

	logic [SIZE_REG_W-1:0]    row_size;
	logic [SIZE_REG_W-1:0]    inner_size;
	logic [SIZE_REG_W-1:0]    col_size;
	logic signed [ELEM_W-1:0] left_mem  [DIM*DIM];
	logic signed [ELEM_W-1:0] right_mem [DIM*DIM];
	result_word_t             expected_words [$];
	int                       errors;

	// sizes above the ram dimension behave as the full dimension
	function automatic int clamp_size(input logic [SIZE_REG_W-1:0] size);
		return (size > DIM) ? DIM : int'(size);
	endfunction

	// dot product of one left row and one right column, wrapped to 32 bits
	function automatic result_word_t predict_product(input logic [INDEX_W-1:0] row,
			input logic [INDEX_W-1:0] col);
		result_word_t      word;
		logic [ELEM_W-1:0] acc;
		int                inner;
		word  = '0;
		acc   = '0;
		inner = clamp_size(inner_size);
		if (row >= clamp_size(row_size) || col >= clamp_size(col_size)) begin
			word.out_of_range = 1'b1;
		end else begin
			for (int z = 0; z < inner; z++)
				acc += left_mem[{row, z[INDEX_W-1:0]}] * right_mem[{z[INDEX_W-1:0], col}];
			word.product = acc;
		end
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_size   <= SIZE_RESET;
			inner_size <= SIZE_RESET;
			col_size   <= SIZE_RESET;
			expected_words.delete();
			pending_count  <= 0;
			mismatch_count <= errors;
		end else begin
			// result word against the oldest expectation
			if (result_valid) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word: product_value %0d out_of_range %0b",
						product_value, out_of_range);
					errors++;
				end else begin
					result_word_t want;
					want = expected_words.pop_front();
					if (product_value !== want.product) begin
						$error("product_value mismatch: expected %0d, actual %0d",
							want.product, product_value);
						errors++;
					end
					if (out_of_range !== want.out_of_range) begin
						$error("out_of_range mismatch: expected %0b, actual %0b",
							want.out_of_range, out_of_range);
						errors++;
					end
				end
			end

			// size registers
			if (cfg_write) begin
				case (cfg_index)
					REG_ROW_COUNT:   row_size   <= cfg_data;
					REG_INNER_COUNT: inner_size <= cfg_data;
					REG_COL_COUNT:   col_size   <= cfg_data;
					default: ;
				endcase
			end

			// accepted command word
			if (start && !busy) begin
				case (mode)
					MODE_WRITE_LEFT: begin
						if (row_index < clamp_size(row_size) && col_index < clamp_size(inner_size))
							left_mem[{row_index, col_index}] <= element_value;
					end
					MODE_WRITE_RIGHT: begin
						if (row_index < clamp_size(inner_size) && col_index < clamp_size(col_size))
							right_mem[{row_index, col_index}] <= element_value;
					end
					MODE_COMPUTE: expected_words.push_back(predict_product(row_index, col_index));
					default: ;
				endcase
			end

			pending_count  <= expected_words.size();
			mismatch_count <= errors;
		end
	end

endmodule

/* tb/sv/integer_matrix_multiply_unit_tb.sv */
// testbench top for the integer matrix multiply unit: stimulus, size phases and verdict
module integer_matrix_multiply_unit_tb;
	import imm_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 72;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_WORDS   = 90;
	localparam int DIM           = MAX_DIM_DEF;

	localparam logic [MODE_W-1:0]        MODE_UNUSED = 2'd3;
	localparam logic signed [ELEM_W-1:0] ELEM_MIN    = 32'sh8000_0000;
	localparam logic signed [ELEM_W-1:0] ELEM_MAX    = 32'sh7fff_ffff;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [SIZE_REG_W-1:0]    cfg_data;
	logic                     start;
	logic                     busy;
	logic [MODE_W-1:0]        mode;
	logic [INDEX_W-1:0]       row_index;
	logic [INDEX_W-1:0]       col_index;
	logic signed [ELEM_W-1:0] element_value;
	logic                     result_valid;
	logic signed [ELEM_W-1:0] product_value;
	logic                     out_of_range;
	int                       mismatch_count;
	int                       pending_count;

	// stimulus view of the sizes and of which ram entries hold data
	int rows_eff  = DIM;
	int inner_eff = DIM;
	int cols_eff  = DIM;
	bit left_done  [DIM*DIM];
	bit right_done [DIM*DIM];
	bit idle_on;
	int words_sent;
	int computes_sent;
	int settings_made;
	int cycle_count;

	integer_matrix_multiply_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.result_valid  (result_valid),
		.product_value (product_value),
		.out_of_range  (out_of_range)
	);

	integer_matrix_multiply_unit_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.row_index      (row_index),
		.col_index      (col_index),
		.element_value  (element_value),
		.result_valid   (result_valid),
		.product_value  (product_value),
		.out_of_range   (out_of_range),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// clock
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int clamp_size(input logic [SIZE_REG_W-1:0] size);
		return (size > DIM) ? DIM : int'(size);
	endfunction

	// element mix: extremes, small signed values and full random words
	function automatic logic signed [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return -1;
			3: return '0;
			4: return $signed($urandom_range(0, 31)) - 16;
			default: return $urandom;
		endcase
	endfunction

	// mostly small sizes, now and then anything the register holds
	function automatic logic [SIZE_REG_W-1:0] pick_size();
		if ($urandom_range(0, 3) == 0)
			return SIZE_REG_W'($urandom_range(0, 127));
		return SIZE_REG_W'($urandom_range(1, 8));
	endfunction

	// one command word, with an optional idle gap before it
	task automatic send_word(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] r,
			input logic [INDEX_W-1:0] c, input logic signed [ELEM_W-1:0] v);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		mode          <= m;
		row_index     <= r;
		col_index     <= c;
		element_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (m)
			MODE_WRITE_LEFT:  if (r < rows_eff && c < inner_eff) left_done[{r, c}] = 1'b1;
			MODE_WRITE_RIGHT: if (r < inner_eff && c < cols_eff) right_done[{r, c}] = 1'b1;
			MODE_COMPUTE:     computes_sent++;
			default: ;
		endcase
		if (m != MODE_UNUSED)
			words_sent++;
	endtask

	// wait for every expected word, then let a full compute latency pass
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// size registers, written back to back while idle
	task automatic set_sizes(input logic [SIZE_REG_W-1:0] r_sz, input logic [SIZE_REG_W-1:0] i_sz,
			input logic [SIZE_REG_W-1:0] c_sz);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_ROW_COUNT;
		cfg_data  <= r_sz;
		@(posedge clk);
		cfg_index <= REG_INNER_COUNT;
		cfg_data  <= i_sz;
		@(posedge clk);
		cfg_index <= REG_COL_COUNT;
		cfg_data  <= c_sz;
		@(posedge clk);
		cfg_write <= 1'b0;
		rows_eff  = clamp_size(r_sz);
		inner_eff = clamp_size(i_sz);
		cols_eff  = clamp_size(c_sz);
		settings_made++;
	endtask

	initial begin
		logic [INDEX_W-1:0]    r;
		logic [INDEX_W-1:0]    c;
		logic [SIZE_REG_W-1:0] sz_r;
		logic [SIZE_REG_W-1:0] sz_i;
		logic [SIZE_REG_W-1:0] sz_c;
		int                    pick;
		int                    phase_start;

		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_ROW_COUNT;
		cfg_data      = '0;
		start         = 1'b0;
		mode          = MODE_WRITE_LEFT;
		row_index     = '0;
		col_index     = '0;
		element_value = '0;
		idle_on       = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 2x2 matrices with extreme elements
		set_sizes(7'd2, 7'd2, 7'd2);
		send_word(MODE_WRITE_LEFT,  6'd0, 6'd0, ELEM_MIN);
		send_word(MODE_WRITE_LEFT,  6'd0, 6'd1, ELEM_MAX);
		send_word(MODE_WRITE_RIGHT, 6'd0, 6'd0, ELEM_MIN);
		send_word(MODE_WRITE_RIGHT, 6'd1, 6'd0, ELEM_MAX);
		send_word(MODE_COMPUTE,     6'd0, 6'd0, '0);
		send_word(MODE_WRITE_LEFT,  6'd1, 6'd0, -1);
		send_word(MODE_WRITE_LEFT,  6'd1, 6'd1, -1);
		send_word(MODE_WRITE_RIGHT, 6'd0, 6'd1, -1);
		send_word(MODE_WRITE_RIGHT, 6'd1, 6'd1, 1);
		send_word(MODE_COMPUTE,     6'd1, 6'd1, ELEM_MAX);
		send_word(MODE_COMPUTE,     6'd0, 6'd1, '0);
		send_word(MODE_COMPUTE,     6'd1, 6'd0, '0);
		// writes just beyond the sizes are dropped
		send_word(MODE_WRITE_LEFT,  6'd2, 6'd0, 7);
		send_word(MODE_WRITE_LEFT,  6'd0, 6'd2, 7);
		send_word(MODE_WRITE_RIGHT, 6'd2, 6'd0, 7);
		send_word(MODE_WRITE_RIGHT, 6'd0, 6'd2, 7);
		send_word(MODE_COMPUTE,     6'd0, 6'd0, '0);
		// result requests outside the sizes
		send_word(MODE_COMPUTE,     6'd2, 6'd0, '0);
		send_word(MODE_COMPUTE,     6'd0, 6'd2, '0);
		send_word(MODE_COMPUTE,     6'd63, 6'd63, -1);
		// unused mode is ignored
		send_word(MODE_UNUSED,      6'd63, 6'd63, -1);

		// random phases, each under its own sizes
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin sz_r = 7'd0;   sz_i = 7'd4;   sz_c = 7'd4;   end
				1: begin sz_r = 7'd4;   sz_i = 7'd0;   sz_c = 7'd4;   end
				2: begin sz_r = 7'd4;   sz_i = 7'd4;   sz_c = 7'd0;   end
				3: begin sz_r = 7'd1;   sz_i = 7'd1;   sz_c = 7'd1;   end
				4: begin sz_r = 7'd64;  sz_i = 7'd64;  sz_c = 7'd64;  end
				5: begin sz_r = 7'd127; sz_i = 7'd127; sz_c = 7'd127; end
				default: begin
					sz_r = pick_size();
					sz_i = pick_size();
					sz_c = pick_size();
				end
			endcase
			set_sizes(sz_r, sz_i, sz_c);
			idle_on     = ($urandom_range(0, 3) != 0);
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				if ($urandom_range(0, 31) == 0)
					idle_on = !idle_on;
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					// compute request, filling any entry it reads that holds no data yet
					if (rows_eff > 0 && cols_eff > 0 && $urandom_range(0, 99) < 85) begin
						r = INDEX_W'($urandom_range(0, rows_eff - 1));
						c = INDEX_W'($urandom_range(0, cols_eff - 1));
					end else begin
						r = INDEX_W'($urandom_range(0, DIM - 1));
						c = INDEX_W'($urandom_range(0, DIM - 1));
					end
					if (r < rows_eff && c < cols_eff) begin
						for (int z = 0; z < inner_eff; z++) begin
							if (!left_done[{r, z[INDEX_W-1:0]}])
								send_word(MODE_WRITE_LEFT, r, z[INDEX_W-1:0], rand_elem());
							if (!right_done[{z[INDEX_W-1:0], c}])
								send_word(MODE_WRITE_RIGHT, z[INDEX_W-1:0], c, rand_elem());
						end
					end
					send_word(MODE_COMPUTE, r, c, rand_elem());
				end else if (pick < 92) begin
					// element write, in range or anywhere
					if ($urandom_range(0, 1) == 0) begin
						if (rows_eff > 0 && inner_eff > 0 && $urandom_range(0, 99) < 60) begin
							r = INDEX_W'($urandom_range(0, rows_eff - 1));
							c = INDEX_W'($urandom_range(0, inner_eff - 1));
						end else begin
							r = INDEX_W'($urandom_range(0, DIM - 1));
							c = INDEX_W'($urandom_range(0, DIM - 1));
						end
						send_word(MODE_WRITE_LEFT, r, c, rand_elem());
					end else begin
						if (inner_eff > 0 && cols_eff > 0 && $urandom_range(0, 99) < 60) begin
							r = INDEX_W'($urandom_range(0, inner_eff - 1));
							c = INDEX_W'($urandom_range(0, cols_eff - 1));
						end else begin
							r = INDEX_W'($urandom_range(0, DIM - 1));
							c = INDEX_W'($urandom_range(0, DIM - 1));
						end
						send_word(MODE_WRITE_RIGHT, r, c, rand_elem());
					end
				end else begin
					// noise in the unused mode
					r = INDEX_W'($urandom_range(0, DIM - 1));
					c = INDEX_W'($urandom_range(0, DIM - 1));
					send_word(MODE_UNUSED, r, c, rand_elem());
				end
			end
		end

		drain();
		$display("run covered %0d command words (%0d compute requests) over %0d size settings",
			words_sent, computes_sent, settings_made);
		if (mismatch_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
